// File: sv/mfb_pkg.sv
// Shared types, constants and face helpers of the mesh face builder.
package mfb_pkg;

    localparam int VERT_W    = 12;
    localparam int FACE_W    = 15;
    localparam int CELL_W    = 14;
    localparam int NUM_VERTS = 4096;
    localparam int NUM_FACES = 32768;
    localparam int NUM_CELLS = 16384;
    localparam int LIST_LEN  = 64;
    localparam int FCNT_W    = FACE_W + 1;
    localparam int CCNT_W    = CELL_W + 1;
    localparam int LEN_W     = 7;
    localparam int K_W       = 6;

    localparam logic [2:0] MODE_TRI  = 3'd0;
    localparam logic [2:0] MODE_QUAD = 3'd1;
    localparam logic [2:0] MODE_TET  = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;
    localparam logic [2:0] MODE_PRI  = 3'd4;
    localparam logic [2:0] MODE_PYR  = 3'd5;

    typedef logic [VERT_W-1:0] t_vert;
    typedef logic [3:0][VERT_W-1:0] t_quad;
    typedef logic [7:0][VERT_W-1:0] t_hexa;

    typedef enum logic [2:0] {
        ST_NEW   = 3'd0,
        ST_BND1  = 3'd1,
        ST_BND2  = 3'd2,
        ST_INNER = 3'd3,
        ST_BFULL = 3'd4,
        ST_FFULL = 3'd5,
        ST_LFULL = 3'd6,
        ST_CFULL = 3'd7
    } t_status;

    typedef struct packed {
        logic       bnd;
        logic [5:0] face_en;
        t_hexa      h;
    } t_item;

    typedef struct packed {
        t_quad      v;
        logic       bnd;
        logic [1:0] cs;
    } t_face;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic [CELL_W-1:0] cell_no;
        t_status           st;
        logic [2:0]        slot;
        logic              last;
    } t_res;

    function automatic t_quad face_q(input t_hexa h, input logic [2:0] f);
        t_quad q;
        unique case (f)
            3'd1: begin
                q[0] = h[4]; q[1] = h[5]; q[2] = h[6]; q[3] = h[7];
            end
            3'd2: begin
                q[0] = h[0]; q[1] = h[1]; q[2] = h[5]; q[3] = h[4];
            end
            3'd3: begin
                q[0] = h[1]; q[1] = h[2]; q[2] = h[6]; q[3] = h[5];
            end
            3'd4: begin
                q[0] = h[3]; q[1] = h[2]; q[2] = h[6]; q[3] = h[7];
            end
            3'd5: begin
                q[0] = h[0]; q[1] = h[3]; q[2] = h[7]; q[3] = h[4];
            end
            default: begin
                q[0] = h[0]; q[1] = h[1]; q[2] = h[2]; q[3] = h[3];
            end
        endcase
        return q;
    endfunction

    function automatic logic face_skip(input t_quad q);
        logic [1:0] rep;
        rep = 2'd0;
        if (q[0] == q[1] || q[0] == q[2] || q[0] == q[3]) rep = rep + 2'd1;
        if (q[1] == q[2] || q[1] == q[3]) rep = rep + 2'd1;
        if (q[2] == q[3]) rep = rep + 2'd1;
        return rep > 2'd1;
    endfunction

endpackage

// File: sv/mfb_front.sv
// Front end: accepts elements, pads them to hexa form, marks live faces, queues them.
module mfb_front import mfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [2:0]  i_mode,
    input  t_vert       i_vert_a,
    input  t_vert       i_vert_b,
    input  t_vert       i_vert_c,
    input  t_vert       i_vert_d,
    input  t_vert       i_vert_e,
    input  t_vert       i_vert_f,
    input  t_vert       i_vert_g,
    input  t_vert       i_vert_h,
    output logic        o_full,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_take
);

    t_item      w_item;
    logic       w_known;
    logic       w_enq;
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_comb begin
        w_item  = '0;
        w_known = 1'b1;
        unique case (i_mode)
            MODE_TRI, MODE_QUAD: begin
                w_item.bnd     = 1'b1;
                w_item.face_en = 6'b000001;
                w_item.h[0]    = i_vert_a;
                w_item.h[1]    = i_vert_b;
                w_item.h[2]    = i_vert_c;
                w_item.h[3]    = (i_mode == MODE_QUAD) ? i_vert_d : i_vert_c;
            end
            MODE_TET: begin
                w_item.h = {i_vert_d, i_vert_d, i_vert_d, i_vert_d,
                            i_vert_c, i_vert_c, i_vert_b, i_vert_a};
            end
            MODE_HEX: begin
                w_item.h = {i_vert_h, i_vert_g, i_vert_f, i_vert_e,
                            i_vert_d, i_vert_c, i_vert_b, i_vert_a};
            end
            MODE_PRI: begin
                w_item.h = {i_vert_f, i_vert_f, i_vert_e, i_vert_d,
                            i_vert_c, i_vert_c, i_vert_b, i_vert_a};
            end
            MODE_PYR: begin
                w_item.h = {i_vert_e, i_vert_e, i_vert_e, i_vert_e,
                            i_vert_d, i_vert_c, i_vert_b, i_vert_a};
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
        if (!w_item.bnd) begin
            for (int f = 0; f < 6; f++) begin
                w_item.face_en[f] = !face_skip(face_q(w_item.h, 3'(f)));
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_enq   = i_push && !o_full && w_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_enq) begin
                r_wp <= ~r_wp;
            end
            if (i_take && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_enq) - 2'(i_take && o_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// File: sv/mfb_back.sv
// Back end: face lookup, creation and cell attach over the face and vertex-list memories.
module mfb_back import mfb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_take,
    output logic  o_clearing,
    output logic  o_empty,
    output t_res  o_res,
    input  logic  i_pop
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_START = 13'b0000000000100,
        S_LEN   = 13'b0000000001000,
        S_LENW  = 13'b0000000010000,
        S_SCAN  = 13'b0000000100000,
        S_HIT   = 13'b0000001000000,
        S_MISS  = 13'b0000010000000,
        S_CKR   = 13'b0000100000000,
        S_CKW   = 13'b0001000000000,
        S_ADR   = 13'b0010000000000,
        S_ADW   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_item  r_item;
    logic [5:0] r_mask;
    t_quad  r_q;
    logic   r_last;
    logic [2:0] r_slot;
    logic [CELL_W-1:0] r_cell;
    logic [CCNT_W-1:0] r_cells;
    logic [FCNT_W-1:0] r_faces;
    logic [VERT_W-1:0] r_clr;
    logic [1:0] r_j;
    logic [LEN_W-1:0] r_len, r_k;
    logic   r_p1, r_p2;
    logic [FACE_W-1:0] r_fidx, r_idx;
    t_face  r_fd;
    t_res   r_res;

    // memories
    logic [LEN_W-1:0]  m_len  [NUM_VERTS];
    logic [FACE_W-1:0] m_list [NUM_VERTS*LIST_LEN];
    t_face             m_face [NUM_FACES];
    logic [LEN_W-1:0]  r_len_rd;
    logic [FACE_W-1:0] r_list_rd;
    t_face             r_face_rd;

    t_res   r_rq [4];
    logic [1:0] r_rwp, r_rrp;
    logic [2:0] r_rcnt;

    logic [2:0] w_f;
    logic [5:0] w_rest;
    logic       w_issue, w_match, w_push;
    logic [2:0] w_occ;
    t_status    w_hit_st;
    logic [VERT_W-1:0] w_qj;

    always_comb begin
        w_f = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (r_mask[i]) w_f = 3'(i);
        end
        w_rest = r_mask & ~(6'b000001 << w_f);
    end

    assign w_qj    = r_q[r_j];
    assign w_issue = (r_k < r_len);

    always_comb begin
        w_match = r_p2;
        for (int i = 0; i < 4; i++) begin
            if (!(r_face_rd.v[i] == r_q[0] || r_face_rd.v[i] == r_q[1] ||
                  r_face_rd.v[i] == r_q[2] || r_face_rd.v[i] == r_q[3])) begin
                w_match = 1'b0;
            end
        end
        w_occ = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (r_q[i] == w_qj) w_occ = w_occ + 3'd1;
        end
        if (r_fd.bnd) begin
            unique case (r_fd.cs)
                2'd0:    w_hit_st = ST_BND1;
                2'd1:    w_hit_st = ST_BND2;
                default: w_hit_st = ST_CFULL;
            endcase
        end else begin
            w_hit_st = ST_INNER;
        end
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_take     = (r_state == S_IDLE) && i_valid;
    assign w_push     = (r_state == S_EMIT) && (r_rcnt != 3'd4);
    assign o_empty    = (r_rcnt == 3'd0);
    assign o_res      = r_rq[r_rrp];

    // memory ports
    always_ff @(posedge i_clk) begin
        r_len_rd  <= m_len[w_qj];
        r_list_rd <= m_list[{r_q[0], r_k[K_W-1:0]}];
        r_face_rd <= m_face[r_list_rd];
        if (r_state == S_CLEAR) begin
            m_len[r_clr] <= '0;
        end else if (r_state == S_ADW) begin
            m_len[w_qj] <= r_len_rd + LEN_W'(1);
        end
        if (r_state == S_ADW) begin
            m_list[{w_qj, r_len_rd[K_W-1:0]}] <= r_faces[FACE_W-1:0];
        end
        if (r_state == S_ADW && r_j == 2'd3) begin
            m_face[r_faces[FACE_W-1:0]] <= '{v: r_q, bnd: r_item.bnd,
                                             cs: r_item.bnd ? 2'd0 : 2'd1};
        end else if (r_state == S_HIT && r_fd.bnd && r_fd.cs < 2'd2) begin
            m_face[r_idx] <= '{v: r_fd.v, bnd: 1'b1, cs: r_fd.cs + 2'd1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cells <= '0;
            r_faces <= '0;
            r_mask  <= '0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
            r_k     <= '0;
            r_len   <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + VERT_W'(1);
                    if (r_clr == VERT_W'(NUM_VERTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_item;
                        r_mask <= i_item.face_en;
                        r_slot <= 3'd0;
                        if (i_item.bnd) begin
                            r_cell  <= '0;
                            r_state <= S_START;
                        end else if (r_cells >= CCNT_W'(NUM_CELLS)) begin
                            r_mask  <= '0;
                            r_res   <= '{face: '0, cell_no: '0, st: ST_CFULL,
                                         slot: 3'd0, last: 1'b1};
                            r_state <= S_EMIT;
                        end else begin
                            r_cell  <= r_cells[CELL_W-1:0];
                            r_cells <= r_cells + CCNT_W'(1);
                            r_state <= (i_item.face_en == 6'd0) ? S_IDLE : S_START;
                        end
                    end
                end
                S_START: begin
                    r_q     <= face_q(r_item.h, w_f);
                    r_mask  <= w_rest;
                    r_last  <= (w_rest == 6'd0);
                    r_j     <= 2'd0;
                    r_state <= r_item.bnd ? S_MISS : S_LEN;
                end
                S_LEN: begin
                    r_state <= S_LENW;
                end
                S_LENW: begin
                    r_len   <= r_len_rd;
                    r_k     <= '0;
                    r_p1    <= 1'b0;
                    r_p2    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_issue) r_k <= r_k + LEN_W'(1);
                    r_p1 <= w_issue;
                    r_p2 <= r_p1;
                    if (r_p1) r_fidx <= r_list_rd;
                    if (w_match) begin
                        r_fd    <= r_face_rd;
                        r_idx   <= r_fidx;
                        r_state <= S_HIT;
                    end else if (!w_issue && !r_p1 && !r_p2) begin
                        r_state <= S_MISS;
                    end
                end
                S_HIT: begin
                    r_res <= '{face: r_idx, cell_no: r_cell, st: w_hit_st,
                               slot: r_slot, last: r_last};
                    if (w_hit_st != ST_CFULL) r_slot <= r_slot + 3'd1;
                    r_state <= S_EMIT;
                end
                S_MISS: begin
                    r_j <= 2'd0;
                    if (r_faces >= FCNT_W'(NUM_FACES)) begin
                        r_res <= '{face: '0, cell_no: r_cell,
                                   st: r_item.bnd ? ST_BFULL : ST_FFULL,
                                   slot: r_slot, last: r_last};
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_CKR;
                    end
                end
                S_CKR: begin
                    r_state <= S_CKW;
                end
                S_CKW: begin
                    if ({1'b0, r_len_rd} + {5'd0, w_occ} > 8'(LIST_LEN)) begin
                        r_res <= '{face: '0, cell_no: r_cell,
                                   st: r_item.bnd ? ST_BFULL : ST_LFULL,
                                   slot: r_slot, last: r_last};
                        r_state <= S_EMIT;
                    end else if (r_j == 2'd3) begin
                        r_j     <= 2'd0;
                        r_state <= S_ADR;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_CKR;
                    end
                end
                S_ADR: begin
                    r_state <= S_ADW;
                end
                S_ADW: begin
                    if (r_j == 2'd3) begin
                        r_res <= '{face: r_faces[FACE_W-1:0], cell_no: r_cell, st: ST_NEW,
                                   slot: r_slot, last: r_last};
                        r_slot  <= r_slot + 3'd1;
                        r_faces <= r_faces + FCNT_W'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_ADR;
                    end
                end
                S_EMIT: begin
                    if (w_push) r_state <= (r_mask == 6'd0) ? S_IDLE : S_START;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwp  <= '0;
            r_rrp  <= '0;
            r_rcnt <= '0;
        end else begin
            if (w_push) r_rwp <= r_rwp + 2'd1;
            if (i_pop && !o_empty) r_rrp <= r_rrp + 2'd1;
            r_rcnt <= r_rcnt + 3'(w_push) - 3'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_rq[r_rwp] <= r_res;
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_len))
        else $error("scan index past list length");
    a_rq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= 3'd4)
        else $error("result queue overflow");
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_take)
        else $error("item taken during clear");
    a_hit_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIT) |=> (r_state == S_EMIT))
        else $error("hit did not produce a result");

endmodule

// File: sv/mesh_face_builder_core.sv
// Top level of the mesh face builder: front end, item queue and back end.
// After reset the block clears the 4096 per-vertex list lengths with full high. An element
// is registered in the front queue and taken by the back end once it is idle; per live
// face the back end then scans the list of the face's first vertex (one list entry read
// a cycle) and either reports a match or creates the face, list checks and appends
// included, or reports a full face table or list. A boundary item skips the lookup. A
// full result queue stalls the back end. Results are held in a four-entry queue.
module mesh_face_builder_core import mfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_mode,
    input  logic [11:0] i_vert_a,
    input  logic [11:0] i_vert_b,
    input  logic [11:0] i_vert_c,
    input  logic [11:0] i_vert_d,
    input  logic [11:0] i_vert_e,
    input  logic [11:0] i_vert_f,
    input  logic [11:0] i_vert_g,
    input  logic [11:0] i_vert_h,
    output logic        empty,
    input  logic        pop,
    output logic [14:0] o_face_index,
    output logic [13:0] o_cell_index,
    output logic [2:0]  o_status,
    output logic [2:0]  o_face_slot,
    output logic        o_last_face
);

    logic  w_front_full, w_clearing, w_valid, w_take;
    t_item w_item;
    t_res  w_res;

    assign full = w_front_full || w_clearing;

    mfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push && !w_clearing),
        .i_mode   (i_mode),
        .i_vert_a (i_vert_a),
        .i_vert_b (i_vert_b),
        .i_vert_c (i_vert_c),
        .i_vert_d (i_vert_d),
        .i_vert_e (i_vert_e),
        .i_vert_f (i_vert_f),
        .i_vert_g (i_vert_g),
        .i_vert_h (i_vert_h),
        .o_full   (w_front_full),
        .o_valid  (w_valid),
        .o_item   (w_item),
        .i_take   (w_take)
    );

    mfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_take     (w_take),
        .o_clearing (w_clearing),
        .o_empty    (empty),
        .o_res      (w_res),
        .i_pop      (pop)
    );

    assign o_face_index = w_res.face;
    assign o_cell_index = w_res.cell_no;
    assign o_status     = 3'(w_res.st);
    assign o_face_slot  = w_res.slot;
    assign o_last_face  = w_res.last;

endmodule
